// File: src/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// shared types, constants and lookup functions of the syllable splitter
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

	localparam int MAX_WORD_DEF = 16;

	// walk modes
	localparam logic [1:0] MODE_SPLIT = 2'd0;
	localparam logic [1:0] MODE_WHOLE = 2'd1;
	localparam logic [1:0] MODE_SPELL = 2'd2;

	// letter codes
	localparam logic [7:0] CH_A  = 8'h61;
	localparam logic [7:0] CH_B  = 8'h62;
	localparam logic [7:0] CH_D  = 8'h64;
	localparam logic [7:0] CH_E  = 8'h65;
	localparam logic [7:0] CH_I  = 8'h69;
	localparam logic [7:0] CH_K  = 8'h6B;
	localparam logic [7:0] CH_L  = 8'h6C;
	localparam logic [7:0] CH_Q  = 8'h71;
	localparam logic [7:0] CH_S  = 8'h73;
	localparam logic [7:0] CH_U  = 8'h75;
	localparam logic [7:0] CH_V  = 8'h76;
	localparam logic [7:0] CH_W  = 8'h77;
	localparam logic [7:0] CH_X  = 8'h78;
	localparam logic [7:0] CH_UC = 8'hFB;
	localparam logic [7:0] CH_UE = 8'hFC;

	localparam logic [4:0] ST_VOWEL = 5'd0;
	localparam logic [4:0] ST_CONS  = 5'd1;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       step;
		logic       tail;
		logic       done;
		logic [1:0] mode;
	} sbf_cmd_t;

	typedef struct packed {
		logic ofree;
		logic whole_ok;
		logic err_end;
		logic last_letter;
		logic more_pieces;
	} sbf_sts_t;

	// pattern machine row: letters to emit and next state on vowel / consonant
	typedef struct packed {
		logic [2:0] kv;
		logic [4:0] nv;
		logic [2:0] kc;
		logic [4:0] nc;
		logic       bc;
		logic       eok;
	} sbf_row_t;

	typedef struct packed {
		logic [2:0] k;
		logic [4:0] nx;
		logic       bad;
	} sbf_next_t;

	typedef struct packed {
		logic [2:0] len;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} sbf_piece_t;

	localparam sbf_row_t FSM_ROWS [18] = '{
		'{3'd1, 5'd0,  3'd0, 5'd2,  1'b0, 1'b1},
		'{3'd0, 5'd3,  3'd0, 5'd4,  1'b0, 1'b0},
		'{3'd1, 5'd3,  3'd0, 5'd5,  1'b0, 1'b1},
		'{3'd2, 5'd0,  3'd0, 5'd6,  1'b0, 1'b1},
		'{3'd0, 5'd7,  3'd0, 5'd8,  1'b0, 1'b0},
		'{3'd2, 5'd3,  3'd0, 5'd9,  1'b0, 1'b1},
		'{3'd2, 5'd3,  3'd0, 5'd10, 1'b0, 1'b1},
		'{3'd3, 5'd0,  3'd0, 5'd11, 1'b0, 1'b1},
		'{3'd0, 5'd12, 3'd0, 5'd0,  1'b1, 1'b0},
		'{3'd3, 5'd3,  3'd0, 5'd13, 1'b0, 1'b1},
		'{3'd3, 5'd3,  3'd0, 5'd14, 1'b0, 1'b1},
		'{3'd3, 5'd3,  3'd0, 5'd15, 1'b0, 1'b1},
		'{3'd4, 5'd0,  3'd0, 5'd16, 1'b0, 1'b1},
		'{3'd3, 5'd7,  3'd0, 5'd0,  1'b1, 1'b1},
		'{3'd4, 5'd3,  3'd4, 5'd4,  1'b0, 1'b1},
		'{3'd4, 5'd3,  3'd0, 5'd17, 1'b0, 1'b1},
		'{3'd4, 5'd3,  3'd5, 5'd1,  1'b0, 1'b1},
		'{3'd5, 5'd3,  3'd0, 5'd0,  1'b1, 1'b1}
	};

	function automatic logic is_vowel(input logic [7:0] c);
		case (c)
			8'h61, 8'h41, 8'hE2, 8'hC2, 8'h65, 8'h45, 8'hFD, 8'h49, 8'hEE, 8'hCE, 8'h69,
			8'hDD, 8'h6F, 8'h4F, 8'hF6, 8'hD6, 8'h75, 8'h55, 8'hFB, 8'hDB, 8'hFC,
			8'hDC: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic sbf_next_t fsm_next(input logic [4:0] st, input logic v);
		sbf_row_t  r;
		sbf_next_t n;
		r = FSM_ROWS[st];
		if (v) begin
			n = '{r.kv, r.nv, 1'b0};
		end else begin
			n = '{r.kc, r.nc, r.bc};
		end
		return n;
	endfunction

	function automatic logic end_ok(input logic [4:0] st);
		return FSM_ROWS[st].eok;
	endfunction

	// one spelled-out piece of a letter
	function automatic sbf_piece_t spell_piece(input logic [7:0] c, input logic [1:0] sub);
		sbf_piece_t p;
		if (is_vowel(c)) begin
			p = '{3'd1, c, 8'h00, 8'h00};
		end else if (c == CH_W) begin
			if (sub == 2'd0) begin
				p = '{3'd3, CH_D, CH_U, CH_B};
			end else if (sub == 2'd1) begin
				p = '{3'd2, CH_L, CH_UE, 8'h00};
			end else begin
				p = '{3'd2, CH_V, CH_E, 8'h00};
			end
		end else if (c == CH_Q) begin
			p = '{3'd2, CH_K, CH_UC, 8'h00};
		end else if (c == CH_X) begin
			p = '{3'd3, CH_I, CH_K, CH_S};
		end else if (c == CH_K) begin
			p = '{3'd2, CH_K, CH_A, 8'h00};
		end else begin
			p = '{3'd2, c, CH_E, 8'h00};
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// File: src/sbf_ram.sv
// ----------------------------------------------------------------------------
// sbf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/sbf_datapath.sv
// ----------------------------------------------------------------------------
// sbf_datapath
// word store, pattern machine, pending letter buffer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_datapath import sbf_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic [7:0] letter,
	input  wire logic     word_end,
	input  wire logic     lexicon_hit,
	input  wire sbf_cmd_t cmd,
	output      sbf_sts_t sts,
	input  wire logic     out_ready,
	output      logic     out_valid,
	output      logic [2:0] syl_len,
	output      logic [7:0] ch0,
	output      logic [7:0] ch1,
	output      logic [7:0] ch2,
	output      logic [7:0] ch3,
	output      logic [7:0] ch4,
	output      logic [7:0] ch5,
	output      logic     final_syllable,
	output      logic     spelled_out
);

	localparam int AW = $clog2(MAX_WORD);
	localparam int LW = $clog2(MAX_WORD + 1);

	logic [LW-1:0] len_q;
	logic [AW-1:0] rp_q;
	logic [4:0]    st_q;
	logic          err_q;
	logic          lex_q;
	logic [1:0]    sub_q;
	logic [2:0]    pc_q;
	logic [7:0]    pb_q [7];
	logic [7:0]    nb [7];

	logic          we;
	logic [7:0]    rdata;
	logic          v_in;
	logic          v_d;
	sbf_next_t     nin;
	sbf_next_t     nwd;
	logic [2:0]    kk;
	logic          last;
	logic          more;
	sbf_piece_t    pc_sp;

	logic          ov_q;
	logic [2:0]    len_o_q;
	logic [7:0]    ch_o_q [6];
	logic          fin_o_q;
	logic          sp_o_q;

	assign we = cmd.load && (len_q < LW'(MAX_WORD));

	sbf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WORD)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(len_q[AW-1:0]),
		.wdata(letter),
		.raddr(rp_q),
		.rdata(rdata)
	);

	assign v_in  = is_vowel(letter);
	assign v_d   = is_vowel(rdata);
	assign nin   = fsm_next(st_q, v_in);
	assign nwd   = fsm_next(st_q, v_d);
	assign kk    = (cmd.mode == MODE_SPLIT && rp_q != '0) ? nwd.k : 3'd0;
	assign last  = (LW'(rp_q) + LW'(1)) == len_q;
	assign more  = (rdata == CH_W) && (sub_q != 2'd2) && (cmd.mode == MODE_SPELL);
	assign pc_sp = spell_piece(rdata, sub_q);

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			nb[i] = (i + int'(kk) < 7) ? pb_q[i + int'(kk)] : 8'h00;
			if (3'(i) == pc_q - kk) begin
				nb[i] = rdata;
			end
		end
	end

	assign sts.ofree       = !ov_q || out_ready;
	assign sts.whole_ok    = lex_q && (len_q >= LW'(2)) && (len_q <= LW'(4));
	assign sts.err_end     = err_q || !end_ok(st_q);
	assign sts.last_letter = last;
	assign sts.more_pieces = more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rp_q  <= '0;
			st_q  <= ST_VOWEL;
			err_q <= 1'b0;
			lex_q <= 1'b0;
			sub_q <= 2'd0;
			pc_q  <= 3'd0;
		end else begin
			if (we) begin
				len_q <= len_q + LW'(1);
				if (len_q == '0) begin
					st_q  <= v_in ? ST_VOWEL : ST_CONS;
					err_q <= 1'b0;
				end else if (!err_q) begin
					if (nin.bad) begin
						err_q <= 1'b1;
					end else begin
						st_q <= nin.nx;
					end
				end
			end
			if (cmd.load && word_end) begin
				lex_q <= lexicon_hit;
			end
			if (cmd.start) begin
				rp_q  <= '0;
				pc_q  <= 3'd0;
				sub_q <= 2'd0;
			end
			if (cmd.step) begin
				if (cmd.mode != MODE_SPELL) begin
					pc_q <= pc_q - kk + 3'd1;
					if (cmd.mode == MODE_SPLIT) begin
						st_q <= (rp_q == '0) ? (v_d ? ST_VOWEL : ST_CONS) : nwd.nx;
					end
				end
				if (more) begin
					sub_q <= sub_q + 2'd1;
				end else begin
					sub_q <= 2'd0;
					if (!last) begin
						rp_q <= rp_q + AW'(1);
					end
				end
			end
			if (cmd.done) begin
				len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 7; i++) begin
				pb_q[i] <= 8'h00;
			end
		end else if (cmd.step && cmd.mode != MODE_SPELL) begin
			for (int i = 0; i < 7; i++) begin
				pb_q[i] <= nb[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			if ((cmd.step && (kk != 3'd0 || cmd.mode == MODE_SPELL)) || cmd.tail) begin
				ov_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tail) begin
			len_o_q <= pc_q;
			for (int i = 0; i < 6; i++) begin
				ch_o_q[i] <= pb_q[i];
			end
			fin_o_q <= 1'b1;
			sp_o_q  <= 1'b0;
		end else if (cmd.step && cmd.mode == MODE_SPELL) begin
			len_o_q   <= pc_sp.len;
			ch_o_q[0] <= pc_sp.c0;
			ch_o_q[1] <= pc_sp.c1;
			ch_o_q[2] <= pc_sp.c2;
			ch_o_q[3] <= 8'h00;
			ch_o_q[4] <= 8'h00;
			ch_o_q[5] <= 8'h00;
			fin_o_q   <= last && !more;
			sp_o_q    <= 1'b1;
		end else if (cmd.step && kk != 3'd0) begin
			len_o_q <= kk;
			for (int i = 0; i < 6; i++) begin
				ch_o_q[i] <= (3'(i) < kk) ? pb_q[i] : 8'h00;
			end
			fin_o_q <= 1'b0;
			sp_o_q  <= 1'b0;
		end
	end

	assign out_valid      = ov_q;
	assign syl_len        = len_o_q;
	assign ch0            = ch_o_q[0];
	assign ch1            = ch_o_q[1];
	assign ch2            = ch_o_q[2];
	assign ch3            = ch_o_q[3];
	assign ch4            = ch_o_q[4];
	assign ch5            = ch_o_q[5];
	assign final_syllable = fin_o_q;
	assign spelled_out    = sp_o_q;

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= 3'd6)
		else $error("pending buffer overrun");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_WORD))
		else $error("word length beyond store");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q && $stable(len_o_q) && $stable(fin_o_q))
		else $error("waiting result beat changed");

endmodule

`default_nettype wire

// File: src/sbf_ctrl.sv
// ----------------------------------------------------------------------------
// sbf_ctrl
// sequencer: letter load, mode choice, store walk and final syllable
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ctrl import sbf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     word_end,
	output      logic     in_ready,
	input  wire sbf_sts_t sts,
	output      sbf_cmd_t cmd
);

	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RD     = 3'd2;
	localparam logic [2:0] S_STEP   = 3'd3;
	localparam logic [2:0] S_TAIL   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] mode_q;
	logic [1:0] mode_d;

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.mode  = mode_q;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && word_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.whole_ok) begin
					mode_d = MODE_WHOLE;
				end else if (sts.err_end) begin
					mode_d = MODE_SPELL;
				end else begin
					mode_d = MODE_SPLIT;
				end
				cmd.start = 1'b1;
				state_d   = S_RD;
			end
			S_RD: begin
				state_d = S_STEP;
			end
			S_STEP: begin
				if (sts.ofree) begin
					cmd.step = 1'b1;
					if (sts.more_pieces) begin
						state_d = S_STEP;
					end else if (sts.last_letter) begin
						if (mode_q == MODE_SPELL) begin
							cmd.done = 1'b1;
							state_d  = S_LOAD;
						end else begin
							state_d = S_TAIL;
						end
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_TAIL: begin
				if (sts.ofree) begin
					cmd.tail = 1'b1;
					cmd.done = 1'b1;
					state_d  = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			mode_q  <= MODE_SPLIT;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.tail) |-> sts.ofree)
		else $error("result issued into a full output register");

	a_tail_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAIL |-> mode_q != MODE_SPELL)
		else $error("tail syllable in spelling mode");

	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == S_RD && !in_ready)
		else $error("walk did not follow start");

endmodule

`default_nettype wire

// File: src/syllable_boundary_fsm.sv
// ----------------------------------------------------------------------------
// syllable_boundary_fsm
// splits a word of letter beats into syllables with a vowel/consonant pattern
// machine, with whole-word and spelled-out fallbacks
// ----------------------------------------------------------------------------
// sequence: letters load while in_ready is high; then a decision state, a read
//   and a step state per stored letter, a step per extra spelled piece and a tail
//   state for the last syllable unless spelled out; held results add waits
// throughput: one word at a time; no letters are taken while the store is walked
// reset: arst_n clears length, pattern state, sequencer and output valid; the
//   word store contents are not cleared
`default_nettype none

module syllable_boundary_fsm import sbf_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] letter,
	input  wire logic       word_end,
	input  wire logic       lexicon_hit,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [2:0] syl_len,
	output      logic [7:0] ch0,
	output      logic [7:0] ch1,
	output      logic [7:0] ch2,
	output      logic [7:0] ch3,
	output      logic [7:0] ch4,
	output      logic [7:0] ch5,
	output      logic       final_syllable,
	output      logic       spelled_out
);

	sbf_cmd_t cmd;
	sbf_sts_t sts;

	sbf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.word_end(word_end),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sbf_datapath #(
		.MAX_WORD(MAX_WORD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.letter        (letter),
		.word_end      (word_end),
		.lexicon_hit   (lexicon_hit),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.syl_len       (syl_len),
		.ch0           (ch0),
		.ch1           (ch1),
		.ch2           (ch2),
		.ch3           (ch3),
		.ch4           (ch4),
		.ch5           (ch5),
		.final_syllable(final_syllable),
		.spelled_out   (spelled_out)
	);

endmodule

`default_nettype wire
